// File: hdl/assert_macros.svh
// Assertion macros shared by the segment lookup modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, cond)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// File: hdl/sflk_pkg.sv
// Constants and types of the segment lookup block.
package sflk_pkg;

   localparam int MAX_SEGMENTS = 16;
   localparam int PAGE_BYTES   = 4096;
   localparam int PAGE_BITS    = $clog2(PAGE_BYTES);
   localparam int IDX_W        = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);

   localparam int ADDR_W       = 32;
   localparam int SIZE_W       = 13;
   localparam int DISP_W       = 12;
   localparam int COUNT_REG_W  = 5;

   localparam logic ACTION_WRITE  = 1'b0;
   localparam logic ACTION_LOOKUP = 1'b1;

   localparam logic REG_PROCESS_BASE  = 1'b0;
   localparam logic REG_SEGMENT_COUNT = 1'b1;

   typedef struct packed {
      logic              loadable;
      logic              writable;
      logic [ADDR_W-1:0] vaddr;
      logic [ADDR_W-1:0] mem_size;
      logic [ADDR_W-1:0] file_size;
      logic [ADDR_W-1:0] file_offset;
   } seg_entry_type;

   typedef struct packed {
      logic              go;
      logic [ADDR_W-1:0] addr;
      logic [CNT_W-1:0]  count;
   } start_type;

   typedef struct packed {
      logic              found;
      logic [ADDR_W-1:0] file_position;
      logic [SIZE_W-1:0] read_size;
      logic              write_permission;
      logic [DISP_W-1:0] lead_offset;
   } result_type;

endpackage

// File: hdl/sflk_seg_mem.sv
// Segment table memory: one write port, one registered read port.
module sflk_seg_mem (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [sflk_pkg::IDX_W-1:0] wr_idx,
   input  sflk_pkg::seg_entry_type wr_data,
   input  logic                   rd_en,
   input  logic [sflk_pkg::IDX_W-1:0] rd_idx,
   output sflk_pkg::seg_entry_type rd_data
);
   import sflk_pkg::*;

   seg_entry_type mem_ff [MAX_SEGMENTS];
   seg_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/sflk_walk.sv
// Lookup sequencer: walks the segment memory and resolves the matching page.
`include "assert_macros.svh"

module sflk_walk (
   input  logic                    clock,
   input  logic                    reset,
   input  sflk_pkg::start_type     start,
   output logic                    idle,
   output logic                    rd_en,
   output logic [sflk_pkg::IDX_W-1:0] rd_idx,
   input  sflk_pkg::seg_entry_type rd_data,
   output logic                    res_valid,
   input  logic                    res_take,
   output sflk_pkg::result_type    result
);
   import sflk_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_WALK = 4'b0010,
      ST_RES  = 4'b0100,
      ST_SIZE = 4'b1000
   } walk_state_type;

   localparam logic [ADDR_W-1:0] PAGE_MASK = ADDR_W'(PAGE_BYTES - 1);
   localparam logic [ADDR_W-1:0] PAGE_VAL  = ADDR_W'(PAGE_BYTES);

   walk_state_type state_ff, state_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  rd_cnt_ff, rd_cnt_in;
   logic              a_vld_ff, a_vld_in;
   logic              b_vld_ff, b_vld_in;

   // stage B payload: one entry with its precomputed sums
   logic [ADDR_W-1:0] b_end_ff, b_end_in;
   logic [ADDR_W-1:0] b_off_ff, b_off_in;
   logic              b_ge_ff, b_ge_in;
   logic              b_unal_ff, b_unal_in;
   logic              b_wr_ff, b_wr_in;
   logic [ADDR_W-1:0] b_fsize_ff, b_fsize_in;
   logic [ADDR_W-1:0] b_foff_ff, b_foff_in;

   // resolve results
   logic                 beyond_ff, beyond_in;
   logic [ADDR_W-1:0]    left_ff, left_in;
   logic [ADDR_W-1:0]    pos_ff, pos_in;
   logic [PAGE_BITS-1:0] disp_ff, disp_in;

   logic              walk_done;
   logic              match;
   logic [ADDR_W-1:0] end_up;
   logic [ADDR_W-1:0] off_pg;
   logic [ADDR_W-1:0] left_disp;
   logic [ADDR_W-1:0] size_full;

   assign idle   = (state_ff == ST_IDLE);
   assign rd_en  = (state_ff == ST_WALK) && (rd_cnt_ff < count_ff);
   assign rd_idx = rd_cnt_ff[IDX_W-1:0];

   // end of range rounded up; an aligned end still gains a full page
   assign end_up = ((b_end_ff >> PAGE_BITS) + ADDR_W'(1)) << PAGE_BITS;
   assign match  = b_vld_ff && b_ge_ff && (addr_ff < end_up);
   assign walk_done = (rd_cnt_ff == count_ff) && !a_vld_ff && !b_vld_ff;

   assign off_pg = b_off_ff & ~PAGE_MASK;

   always_comb begin
      state_in   = state_ff;
      addr_in    = addr_ff;
      count_in   = count_ff;
      rd_cnt_in  = rd_cnt_ff;
      a_vld_in   = 1'b0;
      b_vld_in   = 1'b0;
      b_end_in   = b_end_ff;
      b_off_in   = b_off_ff;
      b_ge_in    = b_ge_ff;
      b_unal_in  = b_unal_ff;
      b_wr_in    = b_wr_ff;
      b_fsize_in = b_fsize_ff;
      b_foff_in  = b_foff_ff;
      beyond_in  = beyond_ff;
      left_in    = left_ff;
      pos_in     = pos_ff;
      disp_in    = disp_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start.go) begin
               addr_in   = start.addr;
               count_in  = start.count;
               rd_cnt_in = '0;
               state_in  = ST_WALK;
            end
         end
         ST_WALK: begin
            a_vld_in = rd_en;
            b_vld_in = a_vld_ff && rd_data.loadable;
            if (rd_en) begin
               rd_cnt_in = rd_cnt_ff + CNT_W'(1);
            end
            if (match) begin
               state_in = ST_RES;
            end else begin
               b_end_in   = rd_data.vaddr + rd_data.mem_size;
               b_off_in   = addr_ff - rd_data.vaddr;
               b_ge_in    = (rd_data.vaddr <= addr_ff);
               b_unal_in  = ((rd_data.vaddr & PAGE_MASK) != '0);
               b_wr_in    = rd_data.writable;
               b_fsize_in = rd_data.file_size;
               b_foff_in  = rd_data.file_offset;
               if (walk_done) begin
                  beyond_in = 1'b1;
                  state_in  = ST_SIZE;
               end
            end
         end
         ST_RES: begin
            beyond_in = (off_pg >= b_fsize_ff);
            left_in   = b_fsize_ff - off_pg;
            pos_in    = b_foff_ff + off_pg;
            if (b_unal_ff && (off_pg == '0)) begin
               disp_in = b_foff_ff[PAGE_BITS-1:0];
            end else begin
               disp_in = '0;
            end
            state_in = ST_SIZE;
         end
         ST_SIZE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // read size: bytes left past the displacement; above one page it becomes one page less the displacement
   assign left_disp = left_ff - ADDR_W'(disp_ff);
   assign size_full = (left_disp > PAGE_VAL) ? (PAGE_VAL - ADDR_W'(disp_ff)) : left_disp;

   assign res_valid = (state_ff == ST_SIZE);

   always_comb begin
      result.found            = !beyond_ff;
      result.file_position    = beyond_ff ? '0 : pos_ff;
      result.read_size        = beyond_ff ? '0 : SIZE_W'(size_full);
      result.write_permission = !beyond_ff && b_wr_ff;
      result.lead_offset      = beyond_ff ? '0 : DISP_W'(disp_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rd_cnt_ff <= '0;
         count_ff  <= '0;
         a_vld_ff  <= 1'b0;
         b_vld_ff  <= 1'b0;
         beyond_ff <= 1'b1;
      end else begin
         state_ff  <= state_in;
         rd_cnt_ff <= rd_cnt_in;
         count_ff  <= count_in;
         a_vld_ff  <= a_vld_in;
         b_vld_ff  <= b_vld_in;
         beyond_ff <= beyond_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff    <= addr_in;
      b_end_ff   <= b_end_in;
      b_off_ff   <= b_off_in;
      b_ge_ff    <= b_ge_in;
      b_unal_ff  <= b_unal_in;
      b_wr_ff    <= b_wr_in;
      b_fsize_ff <= b_fsize_in;
      b_foff_ff  <= b_foff_in;
      left_ff    <= left_in;
      pos_ff     <= pos_in;
      disp_ff    <= disp_in;
   end

   `ASSERT_ALWAYS(a_rd_cnt_bound, clock, reset, rd_cnt_ff <= count_ff)
   `ASSERT_NEXT(a_go_walks, clock, reset, idle && start.go, state_ff == ST_WALK)
   `ASSERT_IMPLY(a_stage_b_from_read, clock, reset, b_vld_ff, $past(rd_en, 2))

endmodule

// File: hdl/segment_fault_file_lookup_top.sv
// Top level: register port, request decode, segment memory, walker and result register.
// A write request stores one segment entry. A lookup request
// walks the entries one per cycle through the single read port of the segment
// memory; the block takes the next request once the walk has matched an entry or
// passed the last one and the result has moved to the output register.
// A finished result waits in the output register, so a new
// request is taken while it is still unclaimed.
`include "assert_macros.svh"

module segment_fault_file_lookup_top (
   input  logic         clock,
   input  logic         reset,
   // action (1)
   input  logic         req_tuser,
   // entry_index[3:0], entry_loadable[4], entry_vaddr[36:5], entry_mem_size[68:37],
   // entry_file_size[100:69], entry_file_offset[132:101], entry_writable[133],
   // lookup_address[165:134], zero fill[167:166]
   input  logic [167:0] req_tdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // found (1)
   output logic         rsp_tuser,
   // file_position[31:0], read_size[44:32], write_permission[45],
   // lead_offset[57:46], zero fill[63:58]
   output logic [63:0]  rsp_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import sflk_pkg::*;

   logic [ADDR_W-1:0]      base_ff, base_in;
   logic [COUNT_REG_W-1:0] count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   result_type             rsp_data_ff, rsp_data_in;

   logic              csr_wr;
   logic              req_acc;
   logic [3:0]        f_index;
   logic [ADDR_W-1:0] f_lookup;
   seg_entry_type     wr_entry;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_idx;
   start_type         start;
   logic              idle;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_idx;
   seg_entry_type     rd_data;
   logic              res_valid;
   logic              res_take;
   result_type        result;

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      base_in  = base_ff;
      count_in = count_ff;
      if (csr_wr) begin
         case (csr_paddr[2])
            REG_PROCESS_BASE:  base_in  = csr_pwdata;
            REG_SEGMENT_COUNT: count_in = csr_pwdata[COUNT_REG_W-1:0];
            default: begin
               base_in = base_ff;
            end
         endcase
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_SEGMENT_COUNT) ?
                       {{(32-COUNT_REG_W){1'b0}}, count_ff} : base_ff;

   // request decode
   assign req_tready = idle;
   assign req_acc    = req_tvalid && req_tready;

   assign f_index              = req_tdata[3:0];
   assign wr_entry.loadable    = req_tdata[4];
   assign wr_entry.vaddr       = req_tdata[36:5];
   assign wr_entry.mem_size    = req_tdata[68:37];
   assign wr_entry.file_size   = req_tdata[100:69];
   assign wr_entry.file_offset = req_tdata[132:101];
   assign wr_entry.writable    = req_tdata[133];
   assign f_lookup             = req_tdata[165:134];

   assign wr_en  = req_acc && (req_tuser == ACTION_WRITE) &&
                   (32'(f_index) < 32'(MAX_SEGMENTS));
   assign wr_idx = IDX_W'(f_index);

   assign start.go    = req_acc && (req_tuser == ACTION_LOOKUP);
   assign start.addr  = f_lookup - base_ff;
   assign start.count = (32'(count_ff) > 32'(MAX_SEGMENTS)) ?
                        CNT_W'(MAX_SEGMENTS) : CNT_W'(count_ff);

   sflk_seg_mem u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_idx  (wr_idx),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_idx  (rd_idx),
      .rd_data (rd_data)
   );

   sflk_walk u_walk (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .idle      (idle),
      .rd_en     (rd_en),
      .rd_idx    (rd_idx),
      .rd_data   (rd_data),
      .res_valid (res_valid),
      .res_take  (res_take),
      .result    (result)
   );

   // output register
   assign res_take = res_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_data_ff.found;
   assign rsp_tdata  = {6'b0, rsp_data_ff.lead_offset, rsp_data_ff.write_permission,
                        rsp_data_ff.read_size, rsp_data_ff.file_position};

   `ASSERT_IMPLY(a_take_has_room, clock, reset, res_take, !rsp_valid_ff || rsp_tready)
   `ASSERT_IMPLY(a_no_accept_busy, clock, reset, res_valid, !req_tready)
   `ASSERT_IMPLY(a_nofound_zero, clock, reset, rsp_valid_ff && !rsp_data_ff.found,
                 rsp_tdata == 64'd0)

endmodule
